@@ hdl/xbd_pkg.sv @@
package xbd_pkg;

	localparam int unsigned ROUNDS = 32;
	localparam int unsigned HALVES = 2 * ROUNDS;
	localparam int unsigned KEYS = 4;
	localparam int unsigned ADDR_W = 4;
	localparam logic [31:0] DELTA = 32'h9E37_79B9;

	localparam logic [31:0] KEY0_RST = 32'hEF54_2687;
	localparam logic [31:0] KEY1_RST = 32'h4D5C_68AC;
	localparam logic [31:0] KEY2_RST = 32'h5427_4EF9;
	localparam logic [31:0] KEY3_RST = 32'h844D_FC52;

	typedef enum logic [1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] cipher_left;
		logic [31:0] cipher_right;
	} cipher_t;

	typedef struct packed {
		logic [31:0] plain_left;
		logic [31:0] plain_right;
	} plain_t;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
	} blk_t;

	// running sum seen by half round h
	function automatic logic [31:0] half_sum(input int unsigned h);
		logic [31:0] steps;
		steps = 32'(ROUNDS - ((h + 1) >> 1));
		return 32'(DELTA * steps);
	endfunction

	// key word picked by half round h
	function automatic logic [1:0] key_sel(input int unsigned h);
		logic [31:0] s;
		s = half_sum(h);
		return (h % 2 == 0) ? s[12:11] : s[1:0];
	endfunction

endpackage

@@ hdl/xtea_block_decrypt.sv @@
// XTEA block decipher, 64-bit block, 128-bit key, ECB.
// Input channel: in_valid/in_stall carry in_data (cipher_left, cipher_right).
// Output channel: out_valid/out_stall carry out_data (plain_left, plain_right).
// An item moves when valid is high and stall is low at a rising clock edge.
// Key words are written over the APB port at byte addresses 0, 4, 8 and 12;
// write them only while no item is in flight. pready is always high.
// The datapath is a chain of 64 cells, one half round each; while out_stall is
// low the chain moves on every clock and a new item can be
// taken every cycle. Each cell holds one item and hands it on when the next
// cell is empty or moving; with out_stall high the chain fills up from the
// end and in_stall rises once the first cell is held, after which items
// wait in place and nothing is lost.
// Reset empties the chain and loads the default key words.
module xtea_block_decrypt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  xbd_pkg::cipher_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output xbd_pkg::plain_t            out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [xbd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import xbd_pkg::*;

	logic [KEYS*32-1:0] keys;
	logic               vld [HALVES+1];
	logic               rdy [HALVES+1];
	blk_t               dat [HALVES+1];

	assign pready = 1'b1;

	xbd_key_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.keys    (keys)
	);

	assign vld[0] = in_valid;
	assign dat[0].left = in_data.cipher_left;
	assign dat[0].right = in_data.cipher_right;
	assign in_stall = !rdy[0];
	assign rdy[HALVES] = !out_stall;

	for (genvar h = 0; h < HALVES; h++) begin : g_cell
		localparam logic [31:0] SUM = half_sum(h);
		localparam logic [1:0]  SEL = key_sel(h);
		logic [31:0] sum_key;

		assign sum_key = SUM + keys[SEL*32 +: 32];

		xbd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[h]),
			.up_data  (dat[h]),
			.up_ready (rdy[h]),
			.dn_ready (rdy[h+1]),
			.sum_key  (sum_key),
			.upd_left (1'(h % 2)),
			.valid    (vld[h+1]),
			.data     (dat[h+1])
		);
	end

	assign out_valid = vld[HALVES];
	assign out_data.plain_left = dat[HALVES].left;
	assign out_data.plain_right = dat[HALVES].right;

`ifndef SYNTHESIS
	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld[1])
		else $error("accepted item did not enter the first cell");

	a_free_output_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_empty_first_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[1] |-> !in_stall)
		else $error("input stalled with first cell empty");
`endif

endmodule

@@ hdl/xbd_cell.sv @@
module xbd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	input  xbd_pkg::blk_t up_data,
	output logic          up_ready,
	input  logic          dn_ready,
	input  logic [31:0]   sum_key,
	input  logic          upd_left,
	output logic          valid,
	output xbd_pkg::blk_t data
);
	import xbd_pkg::*;

	logic        valid_q;
	blk_t        data_q;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] mix;
	logic [31:0] nb;
	blk_t        nxt;

	always_comb begin
		a = upd_left ? up_data.right : up_data.left;
		b = upd_left ? up_data.left : up_data.right;
		mix = (((a << 4) ^ (a >> 5)) + a) ^ sum_key;
		nb = b - mix;
		nxt = up_data;
		if (upd_left) begin
			nxt.left = nb;
		end else begin
			nxt.right = nb;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

@@ hdl/xbd_key_regs.sv @@
module xbd_key_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xbd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic [xbd_pkg::KEYS*32-1:0]  keys
);
	import xbd_pkg::*;

	logic [31:0] key_q [KEYS];
	reg_idx_t    idx;

	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[REG_KEY0] <= KEY0_RST;
			key_q[REG_KEY1] <= KEY1_RST;
			key_q[REG_KEY2] <= KEY2_RST;
			key_q[REG_KEY3] <= KEY3_RST;
		end else if (psel && penable && pwrite) begin
			key_q[idx] <= pwdata;
		end
	end

	always_comb begin
		case (idx)
			REG_KEY0: prdata = key_q[REG_KEY0];
			REG_KEY1: prdata = key_q[REG_KEY1];
			REG_KEY2: prdata = key_q[REG_KEY2];
			REG_KEY3: prdata = key_q[REG_KEY3];
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < KEYS; k++) begin
			keys[k*32 +: 32] = key_q[k];
		end
	end

endmodule
